### rtl/beh_pkg.sv
// ============================================================================
// beh_pkg: shared types and constants
// Holds the bin edge tables, the field widths and the controller to datapath
// command and status types for the binned efficiency histogram.
// ============================================================================
package beh_pkg;

    localparam int PT_W    = 18;
    localparam int ANG_W   = 14;
    localparam int ID_W    = 16;
    localparam int BIN_W   = 6;
    localparam int EFF_W   = 17;
    localparam int OUT_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELECTRON_CUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MUON_CUT     = 1'b1;
    localparam logic [PT_W-1:0] ELECTRON_CUT_RST = 18'd448;
    localparam logic [PT_W-1:0] MUON_CUT_RST     = 18'd320;
    localparam logic [ID_W-1:0] ID_ELECTRON = 16'd11;
    localparam logic [ID_W-1:0] ID_MUON     = 16'd13;
    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam int PT_EDGE_N  = 16;
    localparam int ETA_EDGE_N = 17;
    localparam int PHI_EDGE_N = 13;

    // Edge value i of each table; edges rounded into the input formats.
    function automatic logic signed [19:0] pt_edge(input int i);
        logic signed [19:0] e;
        begin
            case (i)
                0: e = 20'sd320;   1: e = 20'sd384;   2: e = 20'sd448;
                3: e = 20'sd512;   4: e = 20'sd576;   5: e = 20'sd640;
                6: e = 20'sd768;   7: e = 20'sd896;   8: e = 20'sd1024;
                9: e = 20'sd1152; 10: e = 20'sd1280; 11: e = 20'sd1600;
                12: e = 20'sd1920; 13: e = 20'sd2240; 14: e = 20'sd2560;
                default: e = 20'sd3200;
            endcase
            return e;
        end
    endfunction

    function automatic logic signed [15:0] eta_edge(input int i);
        logic signed [15:0] e;
        begin
            case (i)
                0: e = 16'sd0;     1: e = 16'sd205;   2: e = 16'sd410;
                3: e = 16'sd614;   4: e = 16'sd819;   5: e = 16'sd1024;
                6: e = 16'sd1229;  7: e = 16'sd1479;  8: e = 16'sd1604;
                9: e = 16'sd1843; 10: e = 16'sd2048; 11: e = 16'sd2150;
                12: e = 16'sd2253; 13: e = 16'sd2355; 14: e = 16'sd2458;
                15: e = 16'sd2560;
                default: e = 16'sd2662;
            endcase
            return e;
        end
    endfunction

    function automatic logic signed [15:0] phi_edge(input int i);
        logic signed [15:0] e;
        begin
            case (i)
                0: e = -16'sd3277;  1: e = -16'sd2560;  2: e = -16'sd2048;
                3: e = -16'sd1536;  4: e = -16'sd1024;  5: e = -16'sd512;
                6: e = 16'sd0;      7: e = 16'sd512;    8: e = 16'sd1024;
                9: e = 16'sd1536;  10: e = 16'sd2048;  11: e = 16'sd2560;
                default: e = 16'sd3277;
            endcase
            return e;
        end
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new item
        logic clr_step;  // write zero at the clear address
        logic rd_issue;  // drive the memory read address
        logic wr_back;   // write the incremented counters back
        logic div_start; // start the ratio unit
        logic emit;      // present the result
    } beh_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic counted;
        logic div_done;
    } beh_sts_t;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_FETCH = 7'b0000100,
        ST_DATA  = 7'b0001000,
        ST_WRITE = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } beh_state_t;

endpackage

### rtl/binned_efficiency_histogram_top.sv
// ============================================================================
// binned_efficiency_histogram_top: electron and muon efficiency histogram
// Counts events into pt/eta/phi and pt/eta maps and reads out cell ratios.
// ============================================================================
// Usage: raise start with an item while busy is low; the item is taken at
// that edge. A count item (op 0) does a read-modify-write of the four
// counter memories through the single port of each counter RAM; an item
// with an ignored id leaves the memories untouched. A read item
// (op 1) fetches the cell and runs a bit-serial divider, one quotient bit
// per cycle. result_valid is registered from the output state and rises
// as the block returns to idle, so the next item can be taken then; the
// result stands one cycle and cannot be held off.
// Configuration writes (cfg_we, cfg_index, cfg_data) land at once.
// After reset the block clears its counters, one cell per cycle, over
// all 2*(PT+2)*(ETA+2)*(PHI+2) cells (8568 at defaults) with busy high.
// ============================================================================
module binned_efficiency_histogram_top #(
    parameter int PT_BIN_COUNT  = 15,
    parameter int ETA_BIN_COUNT = 16,
    parameter int PHI_BIN_COUNT = 12,
    parameter int COUNT_BITS    = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               cfg_we,
    input  logic [beh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [beh_pkg::PT_W-1:0]           cfg_data,
    input  logic                               op,
    input  logic [beh_pkg::PT_W-1:0]           gen_pt,
    input  logic signed [beh_pkg::ANG_W-1:0]   gen_eta,
    input  logic signed [beh_pkg::ANG_W-1:0]   gen_phi,
    input  logic signed [beh_pkg::ID_W-1:0]    particle_id,
    input  logic                               passed,
    input  logic [beh_pkg::PT_W-1:0]           reco_pt,
    input  logic                               read_species,
    input  logic                               read_plane,
    input  logic [4:0]                         read_pt_bin,
    input  logic [4:0]                         read_eta_bin,
    input  logic [3:0]                         read_phi_bin,
    output logic                               result_valid,
    output logic [beh_pkg::EFF_W-1:0]          efficiency,
    output logic [beh_pkg::OUT_W-1:0]          pass_count,
    output logic [beh_pkg::OUT_W-1:0]          all_count
);
    import beh_pkg::*;

    beh_cmd_t cmd;
    beh_sts_t sts;

    beh_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd));

    beh_dp #(
        .PT_BIN_COUNT(PT_BIN_COUNT), .ETA_BIN_COUNT(ETA_BIN_COUNT),
        .PHI_BIN_COUNT(PHI_BIN_COUNT), .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .op(op), .gen_pt(gen_pt), .gen_eta(gen_eta), .gen_phi(gen_phi),
        .particle_id(particle_id), .passed(passed), .reco_pt(reco_pt),
        .read_species(read_species), .read_plane(read_plane),
        .read_pt_bin(read_pt_bin), .read_eta_bin(read_eta_bin),
        .read_phi_bin(read_phi_bin), .result_valid(result_valid),
        .efficiency(efficiency), .pass_count(pass_count), .all_count(all_count));

    // A result shows only once the block is idle again.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while busy");

    // Commands are mutually exclusive.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.clr_step, cmd.rd_issue, cmd.wr_back, cmd.div_start,
                  cmd.emit}))
        else $error("conflicting datapath commands");

    // Efficiency never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (efficiency <= 17'd65536))
        else $error("efficiency above one");

endmodule

### rtl/beh_ram.sv
// ============================================================================
// beh_ram: generic single-port RAM
// One access per cycle, read data registered; a write reads the old word.
// ============================================================================
module beh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/beh_ctrl.sv
// ============================================================================
// beh_ctrl: sequencing controller
// Runs the clearing pass after reset, then steps each item through fetch,
// read-modify-write, or division and result strobe.
// ============================================================================
module beh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  beh_pkg::beh_sts_t sts,
    output beh_pkg::beh_cmd_t cmd
);
    import beh_pkg::*;

    beh_state_t state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (sts.is_read || sts.counted)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next = ST_DATA;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DATA:
            begin
                if (sts.is_read)
                begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.wr_back = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                cmd.emit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### rtl/beh_dp.sv
// ============================================================================
// beh_dp: histogram datapath
// Binning, cell addressing, counter memories with saturating increment and
// a bit-serial restoring divider for the efficiency ratio.
// ============================================================================
module beh_dp #(
    parameter int PT_BIN_COUNT  = 15,
    parameter int ETA_BIN_COUNT = 16,
    parameter int PHI_BIN_COUNT = 12,
    parameter int COUNT_BITS    = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  beh_pkg::beh_cmd_t                       cmd,
    output beh_pkg::beh_sts_t                       sts,
    input  logic                                    cfg_we,
    input  logic [beh_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [beh_pkg::PT_W-1:0]                cfg_data,
    input  logic                                    op,
    input  logic [beh_pkg::PT_W-1:0]                gen_pt,
    input  logic signed [beh_pkg::ANG_W-1:0]        gen_eta,
    input  logic signed [beh_pkg::ANG_W-1:0]        gen_phi,
    input  logic signed [beh_pkg::ID_W-1:0]         particle_id,
    input  logic                                    passed,
    input  logic [beh_pkg::PT_W-1:0]                reco_pt,
    input  logic                                    read_species,
    input  logic                                    read_plane,
    input  logic [4:0]                              read_pt_bin,
    input  logic [4:0]                              read_eta_bin,
    input  logic [3:0]                              read_phi_bin,
    output logic                                    result_valid,
    output logic [beh_pkg::EFF_W-1:0]               efficiency,
    output logic [beh_pkg::OUT_W-1:0]               pass_count,
    output logic [beh_pkg::OUT_W-1:0]               all_count
);
    import beh_pkg::*;

    localparam int NPT   = PT_BIN_COUNT + 2;
    localparam int NETA  = ETA_BIN_COUNT + 2;
    localparam int NPHI  = PHI_BIN_COUNT + 2;
    localparam int PLANE_DEPTH = 2 * NPT * NETA;
    localparam int CELL_DEPTH  = PLANE_DEPTH * NPHI;
    localparam int PA_W = $clog2(PLANE_DEPTH);
    localparam int CA_W = $clog2(CELL_DEPTH);
    localparam int PT_NE  = (PT_BIN_COUNT + 1 < PT_EDGE_N) ? PT_BIN_COUNT + 1 : PT_EDGE_N;
    localparam int ETA_NE = (ETA_BIN_COUNT + 1 < ETA_EDGE_N) ? ETA_BIN_COUNT + 1
                                                              : ETA_EDGE_N;
    localparam int PHI_NE = (PHI_BIN_COUNT + 1 < PHI_EDGE_N) ? PHI_BIN_COUNT + 1
                                                              : PHI_EDGE_N;
    localparam int NUM_W = COUNT_BITS + 16;
    localparam int DCNT_W = $clog2(NUM_W + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Configuration registers.
    logic [PT_W-1:0] ecut_reg, mcut_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ecut_reg <= ELECTRON_CUT_RST;
            mcut_reg <= MUON_CUT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ELECTRON_CUT)
            begin
                ecut_reg <= cfg_data;
            end
            else if (cfg_index == CFG_MUON_CUT)
            begin
                mcut_reg <= cfg_data;
            end
        end
    end

    // Binning of the incoming event against the edge tables.
    logic signed [ID_W:0]   id_abs;
    logic signed [ANG_W:0]  eta_abs;
    logic [BIN_W-1:0]       pb, eb, fb;
    logic                   is_e, is_m, pass_ok;

    always_comb
    begin
        id_abs  = particle_id[ID_W-1] ? -{particle_id[ID_W-1], particle_id}
                                      : {particle_id[ID_W-1], particle_id};
        eta_abs = gen_eta[ANG_W-1] ? -{gen_eta[ANG_W-1], gen_eta}
                                   : {gen_eta[ANG_W-1], gen_eta};
        is_e = (id_abs == $signed({1'b0, ID_ELECTRON}));
        is_m = (id_abs == $signed({1'b0, ID_MUON}));
        pb = '0;
        eb = '0;
        fb = '0;
        for (int i = 0; i < PT_NE; i++)
        begin
            if ($signed({2'b00, gen_pt}) >= pt_edge(i))
            begin
                pb = BIN_W'(i + 1);
            end
        end
        for (int i = 0; i < ETA_NE; i++)
        begin
            if ($signed({eta_abs[ANG_W], eta_abs}) >= eta_edge(i))
            begin
                eb = BIN_W'(i + 1);
            end
        end
        for (int i = 0; i < PHI_NE; i++)
        begin
            if ($signed({{2{gen_phi[ANG_W-1]}}, gen_phi}) >= phi_edge(i))
            begin
                fb = BIN_W'(i + 1);
            end
        end
        pass_ok = passed && (reco_pt > (is_e ? ecut_reg : mcut_reg));
    end

    // Item registers captured on load.
    logic             is_read_reg, counted_reg, pass_reg, plane_reg, valid_rd_reg, sp_reg;
    logic [BIN_W-1:0] pb_reg, eb_reg, fb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_read_reg <= 1'b0;
            counted_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            is_read_reg <= (op == OP_READ);
            counted_reg <= (op == OP_COUNT) && (is_e || is_m);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pass_reg  <= pass_ok;
            plane_reg <= read_plane;
            if (op == OP_READ)
            begin
                sp_reg <= read_species;
                pb_reg <= BIN_W'(read_pt_bin);
                eb_reg <= BIN_W'(read_eta_bin);
                fb_reg <= BIN_W'(read_phi_bin);
                valid_rd_reg <= (32'(read_pt_bin) < NPT) && (32'(read_eta_bin) < NETA)
                    && (read_plane || (32'(read_phi_bin) < NPHI));
            end
            else
            begin
                sp_reg <= is_m;
                pb_reg <= pb;
                eb_reg <= eb;
                fb_reg <= fb;
                valid_rd_reg <= 1'b1;
            end
        end
    end

    // Cell addresses, each a combinational multiply-add.
    logic [PA_W-1:0] pidx;
    logic [CA_W-1:0] cidx;
    assign pidx = PA_W'((32'(sp_reg) * NPT + 32'(pb_reg)) * NETA + 32'(eb_reg));
    assign cidx = CA_W'(32'(pidx) * NPHI + 32'(fb_reg));

    // Clearing pass over the cell memories; the plane memories fit inside it.
    logic [CA_W-1:0] clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    assign sts.clr_last = (32'(clr_reg) == CELL_DEPTH - 1);

    // Counter memories.
    logic [COUNT_BITS-1:0] pc_q, ac_q, pp_q, ap_q;
    logic [COUNT_BITS-1:0] pc_inc, ac_inc, pp_inc, ap_inc;
    logic [CA_W-1:0] c_addr;
    logic [PA_W-1:0] p_addr;
    logic            c_we, p_we;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    always_comb
    begin
        c_addr = cmd.clr_step ? clr_reg : cidx;
        p_addr = cmd.clr_step ? clr_reg[PA_W-1:0] : pidx;
        c_we   = cmd.clr_step || cmd.wr_back;
        p_we   = (cmd.clr_step && (32'(clr_reg) < PLANE_DEPTH)) || cmd.wr_back;
        ac_inc = cmd.clr_step ? '0 : sat_inc(ac_q);
        ap_inc = cmd.clr_step ? '0 : sat_inc(ap_q);
        pc_inc = cmd.clr_step ? '0 : (pass_reg ? sat_inc(pc_q) : pc_q);
        pp_inc = cmd.clr_step ? '0 : (pass_reg ? sat_inc(pp_q) : pp_q);
    end

    beh_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELL_DEPTH)) u_pass_cells (
        .clk(clk), .we(c_we), .addr(c_addr), .wdata(pc_inc), .rdata(pc_q));
    beh_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELL_DEPTH)) u_all_cells (
        .clk(clk), .we(c_we), .addr(c_addr), .wdata(ac_inc), .rdata(ac_q));
    beh_ram #(.WIDTH(COUNT_BITS), .DEPTH(PLANE_DEPTH)) u_pass_plane (
        .clk(clk), .we(p_we), .addr(p_addr), .wdata(pp_inc), .rdata(pp_q));
    beh_ram #(.WIDTH(COUNT_BITS), .DEPTH(PLANE_DEPTH)) u_all_plane (
        .clk(clk), .we(p_we), .addr(p_addr), .wdata(ap_inc), .rdata(ap_q));

    // Bit-serial restoring divider: one quotient bit per cycle.
    logic [COUNT_BITS-1:0] p_sel, a_sel, p_hold_reg, a_hold_reg, den_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [COUNT_BITS:0]   rem_reg, rem_sh;
    logic [DCNT_W-1:0]     dcnt_reg;
    logic                  div_busy_reg;

    always_comb
    begin
        p_sel = '0;
        a_sel = '0;
        if (valid_rd_reg)
        begin
            p_sel = plane_reg ? pp_q : pc_q;
            a_sel = plane_reg ? ap_q : ac_q;
        end
        rem_sh = {rem_reg[COUNT_BITS-1:0], num_reg[NUM_W-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            dcnt_reg     <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            dcnt_reg     <= DCNT_W'(NUM_W);
        end
        else if (div_busy_reg)
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
            if (dcnt_reg == DCNT_W'(1))
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            p_hold_reg <= p_sel;
            a_hold_reg <= a_sel;
            den_reg    <= a_sel;
            num_reg    <= {p_sel, 16'h0000};
            rem_reg    <= '0;
        end
        else if (div_busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_reg <= rem_sh - {1'b0, den_reg};
                num_reg <= {num_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign sts.div_done = div_busy_reg && (dcnt_reg == DCNT_W'(1));
    assign sts.is_read  = is_read_reg;
    assign sts.counted  = counted_reg;

    // Result register, one strobe per read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (den_reg == '0)
            begin
                efficiency <= '0;
            end
            else if (num_reg > NUM_W'(65536))
            begin
                efficiency <= EFF_W'(65536);
            end
            else
            begin
                efficiency <= EFF_W'(num_reg);
            end
            pass_count <= OUT_W'(p_hold_reg);
            all_count  <= OUT_W'(a_hold_reg);
        end
    end

endmodule
